// File: rtl/core/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, masked while reset is high
`define GPFE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define GPFE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gpfe_pkg.sv
// shared types and constants for the gated pulse feature extractor
// no dependencies
package gpfe_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 28;
  localparam int OFF_W     = 12;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 13;
  localparam int CFG_W     = 16;
  localparam int MAX_GATE  = 4096;
  localparam int INDEX_MAX = (1 << IDX_W) - 1;

  typedef enum logic [1:0] {
    CFG_GATE_START  = 2'd0,
    CFG_GATE_LENGTH = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_addr_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_waveform;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    gate_sum;
    logic signed [SAMPLE_W-1:0] peak_value;
    logic [OFF_W-1:0]           peak_offset;
    logic [LEN_W-1:0]           over_count;
    logic [OFF_W-1:0]           cross_offset;
    logic                       cross_found;
  } out_word_t;

  // where the current sample falls relative to the gate
  typedef struct packed {
    logic             in_gate;
    logic             first;
    logic             last;
    logic [OFF_W-1:0] off;
  } gate_info_t;

endpackage

// File: rtl/core/gpfe_in_reg.sv
// input register stage holding one accepted word
// depends on gpfe_pkg
module gpfe_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gpfe_pkg::in_word_t in_data,
  input  logic              take,
  output logic              held_valid,
  output gpfe_pkg::in_word_t held
);
  import gpfe_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_data;
    end
  end
endmodule

// File: rtl/core/gpfe_gate_ctrl.sv
// sample index counter and gate window decode
// depends on gpfe_pkg
module gpfe_gate_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   new_waveform,
  input  logic [gpfe_pkg::OFF_W-1:0] gate_start,
  input  logic [gpfe_pkg::LEN_W-1:0] gate_length,
  output gpfe_pkg::gate_info_t   info
);
  import gpfe_pkg::*;

  logic [IDX_W-1:0] sample_index;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] diff;
  logic [LEN_W-1:0] len;

  assign idx = new_waveform ? '0 : sample_index;

  always_comb begin
    if (gate_length == '0) begin
      len = LEN_W'(1);
    end else if (gate_length > LEN_W'(MAX_GATE)) begin
      len = LEN_W'(MAX_GATE);
    end else begin
      len = gate_length;
    end
  end

  assign diff         = idx - IDX_W'(gate_start);
  assign info.in_gate = (idx >= IDX_W'(gate_start)) && (diff < IDX_W'(len));
  assign info.first   = (diff == '0);
  assign info.last    = (diff == IDX_W'(len - LEN_W'(1)));
  assign info.off     = diff[OFF_W-1:0];

  // index saturates, a saturated index is past every gate
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (advance) begin
      sample_index <= (idx == IDX_W'(INDEX_MAX)) ? idx : idx + IDX_W'(1);
    end
  end
endmodule

// File: rtl/core/gpfe_accum.sv
// gate accumulators: sum, peak, count above threshold, first crossing
// depends on gpfe_pkg
module gpfe_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic signed [gpfe_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [gpfe_pkg::SAMPLE_W-1:0] threshold,
  input  gpfe_pkg::gate_info_t          info,
  output gpfe_pkg::out_word_t           result
);
  import gpfe_pkg::*;

  logic signed [SUM_W-1:0]    running_sum, running_sum_next;
  logic signed [SAMPLE_W-1:0] best_value, best_value_next;
  logic [OFF_W-1:0]           best_offset, best_offset_next;
  logic [LEN_W-1:0]           above_count, above_count_next;
  logic [OFF_W-1:0]           first_above_offset, first_above_offset_next;
  logic                       seen_above, seen_above_next;
  logic                       above;

  assign above = sample > threshold;

  always_comb begin
    running_sum_next        = running_sum;
    best_value_next         = best_value;
    best_offset_next        = best_offset;
    above_count_next        = above_count;
    first_above_offset_next = first_above_offset;
    seen_above_next         = seen_above;
    if (info.first) begin
      running_sum_next        = SUM_W'(sample);
      best_value_next         = sample;
      best_offset_next        = '0;
      above_count_next        = LEN_W'(above);
      first_above_offset_next = '0;
      seen_above_next         = above;
    end else begin
      running_sum_next = running_sum + SUM_W'(sample);
      if (sample > best_value) begin
        best_value_next  = sample;
        best_offset_next = info.off;
      end
      if (above) begin
        if (!seen_above) begin
          first_above_offset_next = info.off;
        end
        seen_above_next  = 1'b1;
        above_count_next = above_count + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      best_value         <= '0;
      best_offset        <= '0;
      above_count        <= '0;
      first_above_offset <= '0;
      seen_above         <= 1'b0;
    end else if (update) begin
      running_sum        <= running_sum_next;
      best_value         <= best_value_next;
      best_offset        <= best_offset_next;
      above_count        <= above_count_next;
      first_above_offset <= first_above_offset_next;
      seen_above         <= seen_above_next;
    end
  end

  assign result.gate_sum     = running_sum_next;
  assign result.peak_value   = best_value_next;
  assign result.peak_offset  = best_offset_next;
  assign result.over_count   = above_count_next;
  assign result.cross_offset = seen_above_next ? first_above_offset_next : '0;
  assign result.cross_found  = seen_above_next;
endmodule

// File: rtl/core/gpfe_out_reg.sv
// result register driving the output channel
// depends on gpfe_pkg
module gpfe_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  gpfe_pkg::out_word_t result,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output gpfe_pkg::out_word_t out_data
);
  import gpfe_pkg::*;

  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      out_data <= result;
    end
  end
endmodule

// File: rtl/core/gated_pulse_feature_extractor_core.sv
// top level of the gated pulse feature extractor
// depends on gpfe_pkg, gpfe_in_reg, gpfe_gate_ctrl, gpfe_accum, gpfe_out_reg
//
//  channel  direction  handshake             word
//  in       input      in_valid / in_ready   in_data   (sample, new_waveform)
//  out      output     out_valid / out_ready out_data  (gate features)
//  cfg      input      cfg_wr_en             cfg_addr, cfg_wdata
//
// one word per clock while no stall holds a gate-closing word; a word is first held in the
// input register, then its gate result (the accumulators' next values) is loaded into the
// result register
// synchronous active-high reset clears handshakes, sample index, accumulators
// and loads register defaults (start 0, length 1, threshold 0)
// a stalled result only blocks a word that closes a gate; other words keep
// flowing while the result waits
module gated_pulse_feature_extractor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gpfe_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gpfe_pkg::out_word_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [gpfe_pkg::CFG_W-1:0]    cfg_wdata
);
  import gpfe_pkg::*;

  // configuration registers
  logic [OFF_W-1:0]           gate_start;
  logic [LEN_W-1:0]           gate_length;
  logic signed [SAMPLE_W-1:0] threshold;

  // pipeline control
  logic       held_valid;
  in_word_t   held;
  gate_info_t info;
  out_word_t  result;
  logic       emit;
  logic       load_ok;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_start  <= '0;
      gate_length <= LEN_W'(1);
      threshold   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_GATE_START:  gate_start  <= cfg_wdata[OFF_W-1:0];
        CFG_GATE_LENGTH: gate_length <= cfg_wdata[LEN_W-1:0];
        CFG_THRESHOLD:   threshold   <= cfg_wdata[SAMPLE_W-1:0];
        default: ;  // unused address, write dropped
      endcase
    end
  end

  // a word that closes the gate needs room in the result register
  assign emit    = info.in_gate && info.last;
  assign advance = held_valid && (!emit || load_ok);

  gpfe_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  gpfe_gate_ctrl u_gate_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .new_waveform (held.new_waveform),
    .gate_start   (gate_start),
    .gate_length  (gate_length),
    .info         (info)
  );

  // accumulators only move on words inside the gate
  gpfe_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .update    (advance && info.in_gate),
    .sample    (held.sample),
    .threshold (threshold),
    .info      (info),
    .result    (result)
  );

  gpfe_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid && emit),
    .result    (result),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// File: rtl/core/gpfe_checker.sv
// port-level checks for the gated pulse feature extractor
// depends on gpfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module gpfe_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input gpfe_pkg::out_word_t out_data
);
  import gpfe_pkg::*;

  `GPFE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
  `GPFE_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_data), "stalled result word changed")
  `GPFE_ASSERT(a_cross_count, clk, rst, out_valid |-> (out_data.cross_found == (out_data.over_count != '0)), "crossing flag disagrees with count")
  `GPFE_ASSERT(a_cross_zero, clk, rst, out_valid && !out_data.cross_found |-> out_data.cross_offset == '0, "crossing offset set without crossing")
  `GPFE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result valid right after reset")
endmodule

bind gated_pulse_feature_extractor_core gpfe_checker u_gpfe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
